// File: rtl/esc_unesc_pkg.sv
// ----------------------------------------------------------------------------
// Escaped string unescaper package
// Item types, escape state and character helpers shared by the decoder
// and the top level.
// ----------------------------------------------------------------------------
package esc_unesc_pkg;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       is_last;
    } t_in_item;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       byte_valid;
        logic       string_end;
        logic       failed;
    } t_out_item;

    typedef enum logic [2:0] {
        PH_TEXT = 3'b001,
        PH_ESC  = 3'b010,
        PH_HEX  = 3'b100
    } t_phase;

    typedef struct packed {
        t_phase     phase;
        logic [7:0] first_digit;
        logic       error_seen;
    } t_esc_state;

    localparam t_esc_state ESC_STATE_RESET = '{
        phase:       PH_TEXT,
        first_digit: 8'h00,
        error_seen:  1'b0
    };

    localparam logic [7:0] CH_BACKSLASH = 8'h5C;
    localparam logic [7:0] CH_DQUOTE    = 8'h22;
    localparam logic [7:0] CH_SQUOTE    = 8'h27;
    localparam logic [7:0] CH_B         = 8'h62;
    localparam logic [7:0] CH_N         = 8'h6E;
    localparam logic [7:0] CH_T         = 8'h74;
    localparam logic [7:0] CH_F         = 8'h66;
    localparam logic [7:0] CH_R         = 8'h72;
    localparam logic [7:0] CH_0         = 8'h30;
    localparam logic [7:0] CH_9         = 8'h39;
    localparam logic [7:0] CH_LA        = 8'h61;
    localparam logic [7:0] CH_LF        = 8'h66;
    localparam logic [7:0] CH_UA        = 8'h41;
    localparam logic [7:0] CH_UF        = 8'h46;

    localparam logic [7:0] CTL_BS = 8'h08;
    localparam logic [7:0] CTL_LF = 8'h0A;
    localparam logic [7:0] CTL_HT = 8'h09;
    localparam logic [7:0] CTL_FF = 8'h0C;
    localparam logic [7:0] CTL_CR = 8'h0D;

    function automatic logic hex_ok(input logic [7:0] c);
        return (c >= CH_0 && c <= CH_9) || (c >= CH_LA && c <= CH_LF) ||
               (c >= CH_UA && c <= CH_UF);
    endfunction

    function automatic logic [3:0] hex_val(input logic [7:0] c);
        logic [7:0] v;
        v = 8'h00;
        if (c >= CH_0 && c <= CH_9) begin
            v = c - CH_0;
        end else if (c >= CH_LA && c <= CH_LF) begin
            v = c - CH_LA + 8'd10;
        end else if (c >= CH_UA && c <= CH_UF) begin
            v = c - CH_UA + 8'd10;
        end
        return v[3:0];
    endfunction

endpackage

// File: rtl/esc_unesc_decode.sv
// ----------------------------------------------------------------------------
// Escape decoder
// Combinational step of the escape state machine for one input item.
// ----------------------------------------------------------------------------
module esc_unesc_decode
    import esc_unesc_pkg::*;
(
    input  t_esc_state i_state,
    input  t_in_item   i_item,
    output t_esc_state o_state,
    output logic       o_has_result,
    output t_out_item  o_result
);

    logic       have;
    logic [7:0] ob;
    t_esc_state st;
    logic       fail;
    logic [7:0] c;

    always_comb begin
        c    = i_item.data_byte;
        have = 1'b0;
        ob   = 8'h00;
        st   = i_state;
        if (i_state.error_seen) begin
            st.phase = PH_TEXT;
        end else begin
            unique case (i_state.phase)
                PH_ESC: begin
                    st.phase = PH_TEXT;
                    have     = 1'b1;
                    if (c == CH_DQUOTE || c == CH_SQUOTE || c == CH_BACKSLASH) begin
                        ob = c;
                    end else if (c == CH_B) begin
                        ob = CTL_BS;
                    end else if (c == CH_N) begin
                        ob = CTL_LF;
                    end else if (c == CH_T) begin
                        ob = CTL_HT;
                    end else if (c == CH_F) begin
                        ob = CTL_FF;
                    end else if (c == CH_R) begin
                        ob = CTL_CR;
                    end else begin
                        have           = 1'b0;
                        st.first_digit = c;
                        st.phase       = PH_HEX;
                    end
                end
                PH_HEX: begin
                    st.phase = PH_TEXT;
                    if (hex_ok(i_state.first_digit) && hex_ok(c)) begin
                        ob   = {hex_val(i_state.first_digit), hex_val(c)};
                        have = 1'b1;
                    end else begin
                        st.error_seen = 1'b1;
                    end
                end
                default: begin
                    if (c == CH_BACKSLASH) begin
                        st.phase = PH_ESC;
                    end else begin
                        st.phase = PH_TEXT;
                        ob       = c;
                        have     = 1'b1;
                    end
                end
            endcase
        end

        fail = st.error_seen || (st.phase != PH_TEXT);

        o_has_result        = have || i_item.is_last;
        o_result.out_byte   = have ? ob : 8'h00;
        o_result.byte_valid = have;
        o_result.string_end = i_item.is_last;
        o_result.failed     = i_item.is_last && fail;
        o_state             = i_item.is_last ? ESC_STATE_RESET : st;
    end

endmodule

// File: rtl/escaped_string_unescaper.sv
// ----------------------------------------------------------------------------
// Escaped string unescaper
// Decodes backslash escapes in a byte stream, one byte per item, and marks
// the end of each string with a failure flag.
// ----------------------------------------------------------------------------
//  Channel | Handshake                  | Payload
//  input   | i_in_valid / o_in_stall    | i_in_item  (data_byte, is_last)
//  output  | o_out_valid / i_out_stall  | o_out_item (out_byte, byte_valid,
//          |                            |             string_end, failed)
//
// One item per cycle is sustained while the output is not stalled; a result passes
// through the input register and then the result register on its way to the output.
// An item that yields no result leaves the input register without waiting.
// Reset clears the escape state and both valid flags.
// A stall on the output holds the result and backs up to o_in_stall only
// when the item in the input register needs the output slot.
// ----------------------------------------------------------------------------
module escaped_string_unescaper
    import esc_unesc_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_item  i_in_item,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_item
);

    logic       r_in_valid;
    t_in_item   r_in_item;
    logic       r_out_valid;
    t_out_item  r_out_item;
    t_esc_state r_state;

    t_esc_state n_state;
    t_out_item  n_result;
    logic       n_has_result;
    logic       out_free;
    logic       advance;
    logic       in_take;

    esc_unesc_decode u_decode (
        .i_state      (r_state),
        .i_item       (r_in_item),
        .o_state      (n_state),
        .o_has_result (n_has_result),
        .o_result     (n_result)
    );

    assign out_free   = !r_out_valid || !i_out_stall;
    assign advance    = r_in_valid && (!n_has_result || out_free);
    assign o_in_stall = r_in_valid && !advance;
    assign in_take    = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_state     <= ESC_STATE_RESET;
        end else begin
            if (in_take) begin
                r_in_valid <= 1'b1;
                r_in_item  <= i_in_item;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end
            if (advance) begin
                r_state <= n_state;
            end
            if (advance && n_has_result) begin
                r_out_valid <= 1'b1;
                r_out_item  <= n_result;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    a_fail_at_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.failed |-> o_out_item.string_end)
        else $error("failure reported without end of string");

    a_empty_byte_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_item.byte_valid |-> o_out_item.out_byte == 8'h00)
        else $error("out_byte nonzero without a decoded byte");

    a_end_resets: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance && r_in_item.is_last |=> r_state.phase == PH_TEXT && !r_state.error_seen)
        else $error("escape state not cleared after end of string");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && i_out_stall |-> !(advance && n_has_result))
        else $error("held result overwritten");

endmodule
